// File: sv/ttd_pkg.sv
// Shared constants for the touch tap detector: event kinds, register
// indexes, field widths and register reset values. No dependencies.
package ttd_pkg;

	localparam int PIXEL_BITS = 11;
	localparam int TIME_BITS  = 48;

	localparam int FUNC_W  = 3;
	localparam int VAL_W   = 32;
	localparam int SPAN_W  = VAL_W + 1;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 3;
	localparam int SIZE_W  = 12;
	localparam int DEB_W   = 16;

	localparam logic [FUNC_W-1:0] FUNC_POS_X  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_POS_Y  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_TRACK  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_BUTTON = 3'd3;

	localparam logic [CIDX_W-1:0] CFG_X_MIN    = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_X_MAX    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_Y_MIN    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_Y_MAX    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_WIDTH    = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT   = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 3'd6;

	localparam logic [SIZE_W-1:0] WIDTH_RST    = 12'd1072;
	localparam logic [SIZE_W-1:0] HEIGHT_RST   = 12'd1448;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd700;

endpackage

// File: sv/ttd_scaler.sv
// Bit-serial scaler: span * mult by shift-and-add, then a restoring
// divide by den, one bit per cycle. Uses ttd_pkg for the span width.
module ttd_scaler #(
	parameter int PIXEL_BITS = ttd_pkg::PIXEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ttd_pkg::SPAN_W-1:0]    span,
	input  logic [ttd_pkg::SPAN_W-1:0]    den,
	input  logic [PIXEL_BITS-1:0]         mult,
	output logic                          done,
	output logic [ttd_pkg::SPAN_W+PIXEL_BITS-1:0] quot
);

	localparam int N  = ttd_pkg::SPAN_W + PIXEL_BITS;
	localparam int CW = $clog2(N);

	typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV} phase_t;

	phase_t                       phase_q;
	logic [CW-1:0]                cnt_q;
	logic [N-1:0]                 acc_q;
	logic [PIXEL_BITS-1:0]        mult_q;
	logic [ttd_pkg::SPAN_W-1:0]   span_q;
	logic [ttd_pkg::SPAN_W-1:0]   den_q;
	logic [ttd_pkg::SPAN_W-1:0]   rem_q;
	logic                         done_q;
	logic [ttd_pkg::SPAN_W:0]     trial;
	logic                         fits;

	assign trial = {rem_q, acc_q[N-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= CW'(PIXEL_BITS - 1);
					end
				end
				PH_MUL: begin
					if (cnt_q == '0) begin
						phase_q <= PH_DIV;
						cnt_q   <= CW'(N - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				PH_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					acc_q  <= '0;
					mult_q <= mult;
					span_q <= span;
					den_q  <= den;
					rem_q  <= '0;
				end
			end
			PH_MUL: begin
				acc_q  <= {acc_q[N-2:0], 1'b0}
					+ (mult_q[PIXEL_BITS-1] ? N'(span_q) : '0);
				mult_q <= {mult_q[PIXEL_BITS-2:0], 1'b0};
			end
			PH_DIV: begin
				rem_q <= fits ? ttd_pkg::SPAN_W'(trial - {1'b0, den_q})
					: trial[ttd_pkg::SPAN_W-1:0];
				acc_q <= {acc_q[N-2:0], fits};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

// File: sv/touch_tap_detector.sv
// Touch tap detector top level. Depends on ttd_pkg and ttd_scaler.
// A scaled position word passes through the bit-serial multiply and divide in
// ttd_scaler; a clamped position word is stored directly from ST_IDLE; a lift or
// release word that yields a tap passes through ST_EMIT, and waits there while
// an earlier tap still waits in the output register.
// One word is processed at a time; the output register frees the input side.
// arst_n clears all state and loads register defaults asynchronously.
module touch_tap_detector #(
	parameter int PIXEL_BITS = ttd_pkg::PIXEL_BITS,
	parameter int TIME_BITS  = ttd_pkg::TIME_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// event_value [31:0], time_ms [32+TIME_BITS-1:32]
	input  logic [((ttd_pkg::VAL_W+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// func [2:0]
	input  logic [ttd_pkg::FUNC_W-1:0] s_tuser,
	input  logic s_tvalid,
	output logic s_tready,
	// tap_x [PIXEL_BITS-1:0], tap_y [2*PIXEL_BITS-1:PIXEL_BITS]
	output logic [((2*PIXEL_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic cfg_we,
	input  logic [ttd_pkg::CIDX_W-1:0] cfg_index,
	input  logic [ttd_pkg::CFG_W-1:0] cfg_data
);

	localparam int VW  = ttd_pkg::VAL_W;
	localparam int SW  = ttd_pkg::SPAN_W;
	localparam int QW  = SW + PIXEL_BITS;
	localparam int OW  = ((2*PIXEL_BITS+7)/8)*8;
	localparam int SZW = (PIXEL_BITS + 1 > ttd_pkg::SIZE_W) ? PIXEL_BITS + 1
		: ttd_pkg::SIZE_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_EMIT} state_t;

	state_t                     state_q;
	logic [VW-1:0]              x_min_q, x_max_q, y_min_q, y_max_q;
	logic [ttd_pkg::SIZE_W-1:0] width_q, height_q;
	logic [ttd_pkg::DEB_W-1:0]  deb_q;
	logic [PIXEL_BITS-1:0]      pos_x_q, pos_y_q;
	logic                       x_valid_q, y_valid_q, down_q;
	logic [TIME_BITS-1:0]       last_tap_q;
	logic                       axis_y_q;
	logic [PIXEL_BITS:0]        size_q;
	logic                       m_tvalid_q;
	logic [OW-1:0]              m_tdata_q;

	logic [ttd_pkg::FUNC_W-1:0] func;
	logic [VW-1:0]              value;
	logic [TIME_BITS-1:0]       now;
	logic                       accept;
	logic                       is_y;
	logic [VW-1:0]              lo, hi;
	logic [ttd_pkg::SIZE_W-1:0] size_raw;
	logic [SZW-1:0]             size_ext;
	logic [SZW-1:0]             size_lim;
	logic [PIXEL_BITS:0]        size_eff;
	logic                       raw_mode;
	logic                       below;
	logic [PIXEL_BITS-1:0]      raw_pix;
	logic [SW-1:0]              span;
	logic [SW-1:0]              den;
	logic                       scale_go;
	logic                       all_set;
	logic [TIME_BITS:0]         elapsed;
	logic                       time_ok;
	logic                       scale_done;
	logic [QW-1:0]              quot;
	logic [PIXEL_BITS-1:0]      scaled_pix;
	logic                       out_free;

	assign func  = s_tuser;
	assign value = s_tdata[VW-1:0];
	assign now   = s_tdata[VW+TIME_BITS-1:VW];

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign is_y     = func == ttd_pkg::FUNC_POS_Y;
	assign lo       = is_y ? y_min_q : x_min_q;
	assign hi       = is_y ? y_max_q : x_max_q;
	assign size_raw = is_y ? height_q : width_q;
	assign size_ext = SZW'(size_raw);
	assign size_lim = SZW'(1) << PIXEL_BITS;

	always_comb begin
		if (size_raw == '0)
			size_eff = (PIXEL_BITS+1)'(1);
		else if (size_ext > size_lim)
			size_eff = size_lim[PIXEL_BITS:0];
		else
			size_eff = size_ext[PIXEL_BITS:0];
	end

	assign raw_mode = $signed(hi) <= $signed(lo);
	assign below    = $signed(value) < $signed(lo);
	assign span     = {value[VW-1], value} - {lo[VW-1], lo};
	assign den      = {hi[VW-1], hi} - {lo[VW-1], lo};

	always_comb begin
		if (value[VW-1])
			raw_pix = '0;
		else if (value >= VW'(size_eff))
			raw_pix = PIXEL_BITS'(size_eff - 1'b1);
		else
			raw_pix = value[PIXEL_BITS-1:0];
	end

	assign scale_go = accept && !raw_mode && !below
		&& (func == ttd_pkg::FUNC_POS_X || func == ttd_pkg::FUNC_POS_Y);

	assign all_set = down_q && x_valid_q && y_valid_q;
	assign elapsed = {1'b0, now} - {1'b0, last_tap_q};
	assign time_ok = !elapsed[TIME_BITS]
		&& (elapsed[TIME_BITS-1:0] >= TIME_BITS'(deb_q));

	assign scaled_pix = (quot >= QW'(size_q)) ? PIXEL_BITS'(size_q - 1'b1)
		: quot[PIXEL_BITS-1:0];

	ttd_scaler #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_scaler (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scale_go),
		.span  (span),
		.den   (den),
		.mult  (PIXEL_BITS'(size_eff - 1'b1)),
		.done  (scale_done),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= '0;
			x_max_q  <= '0;
			y_min_q  <= '0;
			y_max_q  <= '0;
			width_q  <= ttd_pkg::WIDTH_RST;
			height_q <= ttd_pkg::HEIGHT_RST;
			deb_q    <= ttd_pkg::DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ttd_pkg::CFG_X_MIN:    x_min_q  <= cfg_data[VW-1:0];
				ttd_pkg::CFG_X_MAX:    x_max_q  <= cfg_data[VW-1:0];
				ttd_pkg::CFG_Y_MIN:    y_min_q  <= cfg_data[VW-1:0];
				ttd_pkg::CFG_Y_MAX:    y_max_q  <= cfg_data[VW-1:0];
				ttd_pkg::CFG_WIDTH:    width_q  <= cfg_data[ttd_pkg::SIZE_W-1:0];
				ttd_pkg::CFG_HEIGHT:   height_q <= cfg_data[ttd_pkg::SIZE_W-1:0];
				ttd_pkg::CFG_DEBOUNCE: deb_q    <= cfg_data[ttd_pkg::DEB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			x_valid_q  <= 1'b0;
			y_valid_q  <= 1'b0;
			down_q     <= 1'b0;
			last_tap_q <= '0;
			axis_y_q   <= 1'b0;
			size_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_EMIT)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							ttd_pkg::FUNC_POS_X, ttd_pkg::FUNC_POS_Y: begin
								down_q <= 1'b1;
								if (is_y)
									y_valid_q <= 1'b1;
								else
									x_valid_q <= 1'b1;
								if (raw_mode || below) begin
									if (is_y)
										pos_y_q <= raw_mode ? raw_pix : '0;
									else
										pos_x_q <= raw_mode ? raw_pix : '0;
								end else begin
									axis_y_q <= is_y;
									size_q   <= size_eff;
									state_q  <= ST_SCALE;
								end
							end
							ttd_pkg::FUNC_TRACK: begin
								if (value[VW-1]) begin
									down_q    <= 1'b0;
									x_valid_q <= 1'b0;
									y_valid_q <= 1'b0;
									if (all_set && time_ok) begin
										last_tap_q <= now;
										state_q    <= ST_EMIT;
									end
								end else begin
									down_q <= 1'b1;
								end
							end
							ttd_pkg::FUNC_BUTTON: begin
								if (!value[VW-1] && value != '0) begin
									down_q <= 1'b1;
								end else if (value == '0 && all_set) begin
									down_q    <= 1'b0;
									x_valid_q <= 1'b0;
									y_valid_q <= 1'b0;
									if (time_ok) begin
										last_tap_q <= now;
										state_q    <= ST_EMIT;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCALE: begin
					if (scale_done) begin
						if (axis_y_q)
							pos_y_q <= scaled_pix;
						else
							pos_x_q <= scaled_pix;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OW'({pos_y_q, pos_x_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
